### rtl/cpd_pkg.sv
// Package for the CRC-framed packet deframer.
// Holds result types, event/status codes, register indexes and the CRC-16 byte update.
// No dependencies.
`timescale 1ns / 1ps

package cpd_pkg;

  localparam int unsigned MaxPayload = 256;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcMsb  = 16'h8000;
  localparam logic [15:0] CrcSeed = 16'hFFFF;

  localparam logic [7:0] MagicM = 8'h4D;
  localparam logic [7:0] MagicC = 8'h43;
  localparam logic [7:0] MagicH = 8'h48;
  localparam logic [7:0] MagicT = 8'h54;

  localparam logic [1:0] EvHeader = 2'd0;
  localparam logic [1:0] EvData   = 2'd1;
  localparam logic [1:0] EvReject = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StCrcBad  = 2'd1;
  localparam logic [1:0] StBadVer  = 2'd2;
  localparam logic [1:0] StTooLong = 2'd3;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] RegExpVersion = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxLen     = 2'd1;

  localparam logic [7:0] ExpVersionReset = 8'd1;
  localparam logic [8:0] MaxLenReset     = 9'd256;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] msg_type;
    logic [7:0] frame_flags;
    logic [8:0] payload_len;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] magic_byte(logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = MagicM;
      2'd1:    m = MagicC;
      2'd2:    m = MagicH;
      default: m = MagicT;
    endcase
    return m;
  endfunction

endpackage

### rtl/cpd_in_if.sv
// Input channel of the deframer: one received byte per word.
// No dependencies.
`timescale 1ns / 1ps

interface cpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/cpd_out_if.sv
// Result channel of the deframer: header, payload or reject words.
// No dependencies.
`timescale 1ns / 1ps

interface cpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] msg_type;
  logic [7:0] frame_flags;
  logic [8:0] payload_len;
  logic [7:0] data;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output event_res, output msg_type, output frame_flags,
                  output payload_len, output data, output last, output status,
                  input ready);
  modport sink   (input valid, input event_res, input msg_type, input frame_flags,
                  input payload_len, input data, input last, input status,
                  output ready);
endinterface

### rtl/crc_framed_packet_deframer.sv
// Top level of the CRC-framed packet deframer: input register, parser, result register.
// Depends on cpd_pkg, cpd_in_if, cpd_out_if and cpd_frame_fsm.
`timescale 1ns / 1ps

// Takes one received byte per word and accepts a new word every cycle unless stalled.
// A byte is latched in an input register, parsed as it leaves that register (magic hunt,
// header, length check, one byte-wide CRC-16 update) and its result, if any, lands in the
// result register, from which it is taken when the result side is ready. A stall on the
// result side backs up through the input register. One result at most per byte: a header
// after the CRC field, one per payload byte, or a reject on bad version or length.
module crc_framed_packet_deframer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cpd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cpd_pkg::CfgDataW-1:0]   cfg_data_i,
  cpd_in_if.sink                         rx_i,
  cpd_out_if.source                      res_o
);
  import cpd_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q, out_vld_d;
  res_t       out_q;
  logic       advance, emit;
  res_t       res;
  cfg_t       cfg;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign advance  = in_vld_q && (!out_vld_q || res_o.ready);
  assign rx_i.ready = !in_vld_q || advance;

  cpd_frame_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .byte_i (in_byte_q),
    .emit_o (emit),
    .res_o  (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = emit;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rx_i.ready) begin
        in_vld_q <= rx_i.valid;
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.event_res   = out_q.event_res;
  assign res_o.msg_type    = out_q.msg_type;
  assign res_o.frame_flags = out_q.frame_flags;
  assign res_o.payload_len = out_q.payload_len;
  assign res_o.data        = out_q.data;
  assign res_o.last        = out_q.last;
  assign res_o.status      = out_q.status;

endmodule

### rtl/cpd_frame_fsm.sv
// Frame parser: magic hunt, header fields, length check, CRC-16 and result build.
// Depends on cpd_pkg. Holds the configuration registers.
`timescale 1ns / 1ps

module cpd_frame_fsm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cpd_pkg::cfg_t cfg_i,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  output logic          emit_o,
  output cpd_pkg::res_t res_o
);
  import cpd_pkg::*;

  localparam logic [3:0] PhVersion = 4'd4;
  localparam logic [3:0] PhType    = 4'd5;
  localparam logic [3:0] PhFlags   = 4'd6;
  localparam logic [3:0] PhLenLo   = 4'd7;
  localparam logic [3:0] PhLenHi   = 4'd8;
  localparam logic [3:0] PhCrcLo   = 4'd9;
  localparam logic [3:0] PhCrcHi   = 4'd10;
  localparam logic [3:0] PhPayload = 4'd11;

  logic [7:0]  exp_ver_q;
  logic [8:0]  max_len_q;
  logic [3:0]  phase_q, phase_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic [8:0]  flen_q, flen_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  flags_q, flags_d;

  logic [15:0] crc_b, crc_z, len16;
  logic [8:0]  len_sat, cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q <= ExpVersionReset;
      max_len_q <= MaxLenReset;
    end else if (cfg_i.we) begin
      if (cfg_i.idx == RegExpVersion) begin
        exp_ver_q <= cfg_i.data[7:0];
      end else if (cfg_i.idx == RegMaxLen) begin
        max_len_q <= cfg_i.data;
      end
    end
  end

  assign crc_b   = crc16_byte(crc_q, byte_i);
  assign crc_z   = crc16_byte(crc_q, 8'h00);
  assign len16   = {byte_i, len_lo_q};
  assign len_sat = (len16 > 16'd511) ? 9'd511 : len16[8:0];
  assign cnt_inc = cnt_q + 9'd1;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    rcrc_d   = rcrc_q;
    flen_d   = flen_q;
    len_lo_d = len_lo_q;
    type_d   = type_q;
    flags_d  = flags_q;
    emit_o   = 1'b0;
    res_o    = '0;

    if (phase_q < PhVersion) begin
      if (byte_i == magic_byte(phase_q[1:0])) begin
        phase_d = phase_q + 4'd1;
      end else begin
        phase_d = (byte_i == MagicM) ? 4'd1 : 4'd0;
      end
      if (phase_d == PhVersion) begin
        crc_d = CrcSeed;
        cnt_d = '0;
      end
    end else begin
      case (phase_q)
        PhVersion: begin
          if (byte_i != exp_ver_q) begin
            phase_d = '0; cnt_d = '0; crc_d = CrcSeed; rcrc_d = '0;
            flen_d = '0; len_lo_d = '0; type_d = '0; flags_d = '0;
            emit_o = 1'b1;
            res_o.event_res = EvReject;
            res_o.last      = 1'b1;
            res_o.status    = StBadVer;
          end else begin
            crc_d   = crc_b;
            phase_d = PhType;
          end
        end
        PhType: begin
          type_d  = byte_i;
          crc_d   = crc_b;
          phase_d = PhFlags;
        end
        PhFlags: begin
          flags_d = byte_i;
          crc_d   = crc_b;
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          len_lo_d = byte_i;
          crc_d    = crc_b;
          phase_d  = PhLenHi;
        end
        PhLenHi: begin
          crc_d = crc_b;
          if (len16 > {7'd0, max_len_q} || len16 > 16'(MaxPayload)) begin
            phase_d = '0; cnt_d = '0; crc_d = CrcSeed; rcrc_d = '0;
            flen_d = '0; len_lo_d = '0; type_d = '0; flags_d = '0;
            emit_o = 1'b1;
            res_o.event_res   = EvReject;
            res_o.msg_type    = type_q;
            res_o.frame_flags = flags_q;
            res_o.payload_len = len_sat;
            res_o.last        = 1'b1;
            res_o.status      = StTooLong;
          end else begin
            flen_d  = len16[8:0];
            phase_d = PhCrcLo;
          end
        end
        PhCrcLo: begin
          rcrc_d  = {8'h00, byte_i};
          crc_d   = crc_z;
          phase_d = PhCrcHi;
        end
        PhCrcHi: begin
          emit_o = 1'b1;
          res_o.event_res   = EvHeader;
          res_o.msg_type    = type_q;
          res_o.frame_flags = flags_q;
          if (flen_q == '0) begin
            phase_d = '0; cnt_d = '0; crc_d = CrcSeed; rcrc_d = '0;
            flen_d = '0; len_lo_d = '0; type_d = '0; flags_d = '0;
            res_o.last   = 1'b1;
            res_o.status = (crc_z == {byte_i, rcrc_q[7:0]}) ? StOk : StCrcBad;
          end else begin
            rcrc_d  = {byte_i, rcrc_q[7:0]};
            crc_d   = crc_z;
            cnt_d   = '0;
            phase_d = PhPayload;
            res_o.payload_len = flen_q;
          end
        end
        PhPayload: begin
          emit_o = 1'b1;
          res_o.event_res   = EvData;
          res_o.msg_type    = type_q;
          res_o.frame_flags = flags_q;
          res_o.payload_len = flen_q;
          res_o.data        = byte_i;
          if (cnt_inc >= flen_q) begin
            phase_d = '0; cnt_d = '0; crc_d = CrcSeed; rcrc_d = '0;
            flen_d = '0; len_lo_d = '0; type_d = '0; flags_d = '0;
            res_o.last   = 1'b1;
            res_o.status = (crc_b == rcrc_q) ? StOk : StCrcBad;
          end else begin
            crc_d = crc_b;
            cnt_d = cnt_inc;
          end
        end
        default: begin
          phase_d = '0; cnt_d = '0; crc_d = CrcSeed; rcrc_d = '0;
          flen_d = '0; len_lo_d = '0; type_d = '0; flags_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      cnt_q    <= '0;
      crc_q    <= CrcSeed;
      rcrc_q   <= '0;
      flen_q   <= '0;
      len_lo_q <= '0;
      type_q   <= '0;
      flags_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      rcrc_q   <= rcrc_d;
      flen_q   <= flen_d;
      len_lo_q <= len_lo_d;
      type_q   <= type_d;
      flags_q  <= flags_d;
    end
  end

endmodule

### rtl/cpd_checker.sv
// Port-level checks for the deframer result channel, bound to the top level.
// Depends on cpd_pkg and crc_framed_packet_deframer.
`timescale 1ns / 1ps

module cpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] event_res_i,
  input logic [7:0] data_i,
  input logic       last_i,
  input logic [1:0] status_i
);
  import cpd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(data_i) && $stable(status_i))
    else $error("result word changed while stalled");

  a_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> event_res_i != 2'd3)
    else $error("undefined event code");

  a_mid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !last_i |-> status_i == StOk && event_res_i != EvReject)
    else $error("non-final word with status or reject");

  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && event_res_i == EvReject |->
      last_i && data_i == 8'h00 && (status_i == StBadVer || status_i == StTooLong))
    else $error("malformed reject word");

endmodule

bind crc_framed_packet_deframer cpd_checker u_cpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .event_res_i (res_o.event_res),
  .data_i      (res_o.data),
  .last_i      (res_o.last),
  .status_i    (res_o.status)
);

### verif/tb_top.sv
// Testbench for crc_framed_packet_deframer: byte-stream stimulus with a self-checking predictor.
// Depends on cpd_pkg, cpd_in_if, cpd_out_if and the deframer RTL.
`timescale 1ns / 1ps

module tb_top;
  import cpd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBytes = 56;
  localparam int unsigned SettleCycles = 8;
  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;

  class frame_predictor;
    typedef enum logic [3:0] {
      PhMagic0, PhMagic1, PhMagic2, PhMagic3, PhVersion, PhType, PhFlags,
      PhLenLo, PhLenHi, PhCrcLo, PhCrcHi, PhPayload
    } phase_e;

    logic [7:0]  exp_version;
    logic [8:0]  max_len;
    phase_e      phase;
    logic [8:0]  byte_cnt;
    logic [15:0] crc;
    logic [15:0] rx_crc;
    logic [8:0]  frame_len;
    logic [7:0]  len_lo;
    logic [7:0]  held_type;
    logic [7:0]  held_flags;
    res_t        pending_words[$];

    function new();
      exp_version = ExpVersionReset;
      max_len     = MaxLenReset;
      clear_frame();
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
      end
      return c;
    endfunction

    static function logic [7:0] magic_at(logic [1:0] idx);
      case (idx)
        2'd0:    return MagicM;
        2'd1:    return MagicC;
        2'd2:    return MagicH;
        default: return MagicT;
      endcase
    endfunction

    function void clear_frame();
      phase      = PhMagic0;
      byte_cnt   = '0;
      crc        = CrcSeed;
      rx_crc     = '0;
      frame_len  = '0;
      len_lo     = '0;
      held_type  = '0;
      held_flags = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == RegExpVersion) exp_version = val[7:0];
      else if (idx == RegMaxLen) max_len = val;
    endfunction

    function void push_word(logic [1:0] ev, logic [7:0] typ, logic [7:0] flg,
                            int unsigned len, logic [7:0] dat, logic lst, logic [1:0] st);
      res_t w;
      w.event_res   = ev;
      w.msg_type    = typ;
      w.frame_flags = flg;
      w.payload_len = (len > 511) ? 9'd511 : len[8:0];
      w.data        = dat;
      w.last        = lst;
      w.status      = st;
      pending_words = {pending_words, w};
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned len;
      logic [1:0]  st;
      logic [7:0]  t;
      logic [7:0]  f;
      logic [8:0]  l;
      t = held_type;
      f = held_flags;
      l = frame_len;
      if (phase < PhVersion) begin
        if (b == magic_at(phase[1:0])) phase = phase_e'(phase + 4'd1);
        else phase = (b == MagicM) ? PhMagic1 : PhMagic0;
        if (phase == PhVersion) begin
          crc      = CrcSeed;
          byte_cnt = '0;
        end
        return;
      end
      case (phase)
        PhVersion: begin
          if (b != exp_version) begin
            clear_frame();
            push_word(EvReject, 8'h00, 8'h00, 0, 8'h00, 1'b1, StBadVer);
          end else begin
            crc   = crc_step(crc, b);
            phase = PhType;
          end
        end
        PhType: begin
          held_type = b;
          crc       = crc_step(crc, b);
          phase     = PhFlags;
        end
        PhFlags: begin
          held_flags = b;
          crc        = crc_step(crc, b);
          phase      = PhLenLo;
        end
        PhLenLo: begin
          len_lo = b;
          crc    = crc_step(crc, b);
          phase  = PhLenHi;
        end
        PhLenHi: begin
          len = 32'({b, len_lo});
          crc = crc_step(crc, b);
          if (len > max_len || len > MaxPayload) begin
            clear_frame();
            push_word(EvReject, t, f, len, 8'h00, 1'b1, StTooLong);
          end else begin
            frame_len = len[8:0];
            phase     = PhCrcLo;
          end
        end
        PhCrcLo: begin
          rx_crc = {8'h00, b};
          crc    = crc_step(crc, 8'h00);
          phase  = PhCrcHi;
        end
        PhCrcHi: begin
          rx_crc[15:8] = b;
          crc          = crc_step(crc, 8'h00);
          if (frame_len == 0) begin
            st = (crc == rx_crc) ? StOk : StCrcBad;
            clear_frame();
            push_word(EvHeader, t, f, 0, 8'h00, 1'b1, st);
          end else begin
            byte_cnt = '0;
            phase    = PhPayload;
            push_word(EvHeader, t, f, frame_len, 8'h00, 1'b0, StOk);
          end
        end
        PhPayload: begin
          crc      = crc_step(crc, b);
          byte_cnt = byte_cnt + 9'd1;
          if (byte_cnt >= frame_len) begin
            st = (crc == rx_crc) ? StOk : StCrcBad;
            clear_frame();
            push_word(EvData, t, f, l, b, 1'b1, st);
          end else begin
            push_word(EvData, t, f, l, b, 1'b0, StOk);
          end
        end
        default: clear_frame();
      endcase
    endfunction

    function string check_word(res_t got);
      res_t  want;
      string msg;
      if (pending_words.size() == 0)
        return $sformatf(" unexpected word ev %0d type %02h len %0d data %02h",
                         got.event_res, got.msg_type, got.payload_len, got.data);
      want = pending_words.pop_front();
      msg  = "";
      if (got.event_res !== want.event_res)
        msg = {msg, $sformatf(" event_res %0d/%0d", got.event_res, want.event_res)};
      if (got.msg_type !== want.msg_type)
        msg = {msg, $sformatf(" msg_type %02h/%02h", got.msg_type, want.msg_type)};
      if (got.frame_flags !== want.frame_flags)
        msg = {msg, $sformatf(" frame_flags %02h/%02h", got.frame_flags, want.frame_flags)};
      if (got.payload_len !== want.payload_len)
        msg = {msg, $sformatf(" payload_len %0d/%0d", got.payload_len, want.payload_len)};
      if (got.data !== want.data)
        msg = {msg, $sformatf(" data %02h/%02h", got.data, want.data)};
      if (got.last !== want.last)
        msg = {msg, $sformatf(" last %0b/%0b", got.last, want.last)};
      if (got.status !== want.status)
        msg = {msg, $sformatf(" status %0d/%0d", got.status, want.status)};
      return msg;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cpd_in_if  rx_if ();
  cpd_out_if res_if ();

  crc_framed_packet_deframer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  frame_predictor sb = new();
  bit             idle_on = 1'b1;
  int unsigned    errors = 0;
  int unsigned    cycle_cnt = 0;
  int unsigned    bytes_sent = 0;
  int unsigned    words_seen = 0;
  res_t           got_word;
  string          diff;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_cnt, sb.pending_words.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] mismatch (got/exp):%s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_word.event_res   = res_if.event_res;
      got_word.msg_type    = res_if.msg_type;
      got_word.frame_flags = res_if.frame_flags;
      got_word.payload_len = res_if.payload_len;
      got_word.data        = res_if.data;
      got_word.last        = res_if.last;
      got_word.status      = res_if.status;
      diff = sb.check_word(got_word);
      if (diff != "") report_mismatch(diff);
      words_seen++;
    end
  end

  // result-side backpressure
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_byte(logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // keep = 0 sends the whole frame, otherwise only its first keep bytes
  task automatic send_frame(logic [7:0] ver, logic [7:0] typ, logic [7:0] flg,
                            int unsigned len, logic [15:0] crc_err, int unsigned keep,
                            bit with_payload);
    logic [7:0]  fr[$];
    logic [7:0]  pl[$];
    logic [15:0] crc;
    int unsigned n;
    fr = '{MagicM, MagicC, MagicH, MagicT, ver, typ, flg, len[7:0], len[15:8]};
    if (with_payload)
      for (int i = 0; i < len; i++) pl = {pl, 8'($urandom)};
    crc = CrcSeed;
    for (int i = 4; i < 9; i++) crc = frame_predictor::crc_step(crc, fr[i]);
    crc = frame_predictor::crc_step(crc, 8'h00);
    crc = frame_predictor::crc_step(crc, 8'h00);
    foreach (pl[i]) crc = frame_predictor::crc_step(crc, pl[i]);
    crc = crc ^ crc_err;
    fr = {fr, crc[7:0], crc[15:8]};
    fr = {fr, pl};
    n = (keep == 0 || keep > fr.size()) ? fr.size() : keep;
    for (int i = 0; i < n; i++) send_byte(fr[i]);
  endtask

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned cap;
    logic [7:0]  ver;
    logic [15:0] err;
    kind = $urandom_range(0, 99);
    ver  = sb.exp_version;
    cap  = 32'(sb.max_len);
    if (cap == 0) len = 0;
    else if ($urandom_range(0, 19) == 0) len = cap;
    else if ($urandom_range(0, 9) < 2) len = $urandom_range(0, cap);
    else len = $urandom_range(0, (cap < 6) ? cap : 6);
    err = 16'h0000;
    if (kind < 60) begin
      send_frame(ver, 8'($urandom), 8'($urandom), len, err, 0, 1'b1);
    end else if (kind < 72) begin
      err = 16'($urandom_range(1, 16'hFFFF));
      send_frame(ver, 8'($urandom), 8'($urandom), len, err, 0, 1'b1);
    end else if (kind < 80) begin
      ver = ver ^ 8'($urandom_range(1, 255));
      send_frame(ver, 8'($urandom), 8'($urandom), len, err, 0, 1'b0);
    end else if (kind < 88) begin
      if ($urandom_range(0, 1) == 0) len = cap + 1;
      else len = $urandom_range(cap + 1, 16'hFFFF);
      send_frame(ver, 8'($urandom), 8'($urandom), len, err, 0, 1'b0);
    end else if (kind < 94) begin
      send_frame(ver, 8'($urandom), 8'($urandom), len, err,
                 $urandom_range(1, len + 10), 1'b1);
    end else begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 3) == 0)
          send_byte(frame_predictor::magic_at(2'($urandom_range(0, 3))));
        else
          send_byte(8'($urandom));
      end
    end
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [7:0] ver, logic [8:0] mlen, bit spare);
    logic [CfgDataW-1:0] val;
    if (spare) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= RegSpareA;
      cfg_data_i <= CfgDataW'($urandom);
      @(posedge clk_i);
      cfg_idx_i  <= RegSpareB;
      cfg_data_i <= CfgDataW'($urandom);
      @(posedge clk_i);
    end
    val = {1'($urandom_range(0, 1)), ver};
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegExpVersion;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(RegExpVersion, val);
    cfg_idx_i  <= RegMaxLen;
    cfg_data_i <= mlen;
    @(posedge clk_i);
    sb.write_reg(RegMaxLen, mlen);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(bit allow_idle);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      send_random_frame();
    end
    drain();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= RegExpVersion;
    cfg_data_i    <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // noise, restart on a repeated M, then a bad version
    send_byte(8'hFF);
    send_byte(MagicM);
    send_frame(8'h00, 8'hFF, 8'h00, 0, 16'h0000, 5, 1'b0);
    // too long, length saturates in the reject word
    send_frame(ExpVersionReset, 8'hFF, 8'h00, 16'hFF00, 16'h0000, 9, 1'b0);
    // empty payload, header carries the verdict
    send_frame(ExpVersionReset, 8'h00, 8'hFF, 0, 16'h0000, 0, 1'b0);
    drain();

    program_regs(8'h00, 9'd0, 1'b0);
    run_random(1'b1);
    program_regs(8'hFF, 9'd256, 1'b1);
    run_random(1'b1);
    program_regs(8'($urandom), 9'($urandom_range(0, 256)), 1'b1);
    run_random(1'b1);
    program_regs(8'h01, 9'd1, 1'b0);
    run_random(1'b1);
    program_regs(8'($urandom), 9'd256, 1'b0);
    idle_on = 1'b0;
    run_random(1'b0);

    if (sb.pending_words.size() != 0)
      report_mismatch($sformatf(" %0d expected words never arrived",
                                sb.pending_words.size()));
    $display("Fed %0d bytes under five register settings, checked %0d result words.",
             bytes_sent, words_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
